// File: hdl/u8cp_pkg.sv
`timescale 1ns / 1ps

package u8cp_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00fffd;
  localparam logic [1:0]     CONT_TAG       = 2'b10;

  typedef struct packed {
    logic [1:0]      held;
    logic [2:0]      seq_len;
    logic [CpW-1:0]  partial;
  } seq_state_t;

  // results caused by one byte: replacement flushes, then an optional final result
  typedef struct packed {
    logic [1:0]      flush_cnt;
    logic            has_final;
    logic [CpW-1:0]  final_cp;
    logic            final_eos;
  } burst_t;

endpackage

// File: hdl/utf8_to_codepoint_stream.sv
`timescale 1ns / 1ps
// a byte's first result is offered from registers in the cycle after its transaction
// while out_ready is high: one byte per cycle if each byte gives at most one result;
// a broken sequence replays up to four results, one per cycle, from the result register
// the next byte is taken in the cycle the last pending result leaves
// reset (rst_n low, synchronous) closes any open sequence and drops pending results

module utf8_to_codepoint_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_input_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_end_of_string
);

  u8cp_pkg::seq_state_t state_r, state_nxt;
  u8cp_pkg::burst_t     burst_nxt;

  logic [1:0]  flush_r;
  logic        fin_valid_r;
  logic [20:0] fin_cp_r;
  logic        fin_eos_r;
  logic        in_xfer, out_xfer, last_one;

  u8cp_decode u_decode (
    .in_byte (in_input_byte),
    .cur     (state_r),
    .nxt     (state_nxt),
    .burst   (burst_nxt)
  );

  assign out_valid         = (flush_r != 2'd0) || fin_valid_r;
  assign out_code_point    = (flush_r != 2'd0) ? u8cp_pkg::REPLACEMENT_CP : fin_cp_r;
  assign out_end_of_string = (flush_r == 2'd0) && fin_eos_r;

  assign last_one = ((flush_r == 2'd0) && fin_valid_r) || ((flush_r == 2'd1) && !fin_valid_r);
  assign in_ready = !out_valid || (out_ready && last_one);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      flush_r     <= 2'd0;
      fin_valid_r <= 1'b0;
      fin_eos_r   <= 1'b0;
    end else if (in_xfer) begin
      state_r     <= state_nxt;
      flush_r     <= burst_nxt.flush_cnt;
      fin_valid_r <= burst_nxt.has_final;
      fin_eos_r   <= burst_nxt.final_eos;
    end else if (out_xfer) begin
      if (flush_r != 2'd0) begin
        flush_r <= flush_r - 2'd1;
      end else begin
        fin_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fin_cp_r <= burst_nxt.final_cp;
    end
  end

endmodule

// File: hdl/u8cp_decode.sv
`timescale 1ns / 1ps

module u8cp_decode (
  input  logic [7:0]          in_byte,
  input  u8cp_pkg::seq_state_t cur,
  output u8cp_pkg::seq_state_t nxt,
  output u8cp_pkg::burst_t     burst
);

  logic       is_cont;
  logic [2:0] held_inc;
  logic [20:0] part_shift;

  assign is_cont    = (in_byte[7:6] == u8cp_pkg::CONT_TAG);
  assign held_inc   = {1'b0, cur.held} + 3'd1;
  assign part_shift = {cur.partial[14:0], in_byte[5:0]};

  always_comb begin
    nxt             = '0;
    burst.flush_cnt = 2'd0;
    burst.has_final = 1'b0;
    burst.final_cp  = '0;
    burst.final_eos = 1'b0;
    if (cur.held != 2'd0 && is_cont) begin
      if (held_inc >= cur.seq_len) begin
        burst.has_final = 1'b1;
        burst.final_cp  = part_shift;
      end else begin
        nxt.held    = held_inc[1:0];
        nxt.seq_len = cur.seq_len;
        nxt.partial = part_shift;
      end
    end else begin
      // broken or absent sequence: one replacement per held byte, then decode as lead
      burst.flush_cnt = cur.held;
      if (in_byte == 8'h00) begin
        burst.has_final = 1'b1;
        burst.final_eos = 1'b1;
      end else if (in_byte[7] == 1'b0) begin
        burst.has_final = 1'b1;
        burst.final_cp  = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        nxt.held    = 2'd1;
        nxt.seq_len = 3'd2;
        nxt.partial = {16'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        nxt.held    = 2'd1;
        nxt.seq_len = 3'd3;
        nxt.partial = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        nxt.held    = 2'd1;
        nxt.seq_len = 3'd4;
        nxt.partial = {18'd0, in_byte[2:0]};
      end else begin
        burst.has_final = 1'b1;
        burst.final_cp  = u8cp_pkg::REPLACEMENT_CP;
      end
    end
  end

endmodule

// File: hdl/u8cp_checker.sv
`timescale 1ns / 1ps

module u8cp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_input_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point,
  input logic        out_end_of_string
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_eos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_code_point == 21'd0)
    else $error("terminator with nonzero code point");

  // ascii and nul bytes always produce a result right after the transaction
  a_ascii_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_input_byte[7] |=> out_valid)
    else $error("no result for single-byte character");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte taken while result stalled");

endmodule

bind utf8_to_codepoint_stream u8cp_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_input_byte     (in_input_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_code_point    (out_code_point),
  .out_end_of_string (out_end_of_string)
);
